// File: rtl/assert_macros.svh
// Assertion helper macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/alpq_pkg.sv
package alpq_pkg;
	localparam logic [1:0] OP_EDGE = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	localparam logic [2:0] CFG_MODE = 3'd0;
	localparam logic [2:0] CFG_CDEB = 3'd1;
	localparam logic [2:0] CFG_CTHR = 3'd2;
	localparam logic [2:0] CFG_CUT = 3'd3;
	localparam logic [2:0] CFG_L25 = 3'd4;
	localparam logic [2:0] CFG_L50 = 3'd5;
	localparam logic [2:0] CFG_L75 = 3'd6;
	localparam logic [2:0] CFG_L100 = 3'd7;

	localparam logic [2:0] SEV_INTACT = 3'd0;
	localparam logic [2:0] SEV_MICRO = 3'd1;
	localparam logic [2:0] SEV_MODERATE = 3'd2;
	localparam logic [2:0] SEV_SEVERE = 3'd3;
	localparam logic [2:0] SEV_TOTAL = 3'd4;
	localparam logic [2:0] SEV_CLEARED = 3'd5;

	localparam logic [31:0] WINDOW_MS = 32'd350;
	localparam logic [31:0] RATE_MS = 32'd1000;
	localparam logic [31:0] HOLD_MS = 32'd150;
	localparam logic [31:0] PULSE_MS = 32'd40;
	localparam logic [15:0] HOLD_RATE = 16'd15;
	localparam logic [31:0] HOLD_HITS = 32'd12;

	typedef struct packed {
		logic       start;
		logic [12:0] dividend;
		logic [7:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [12:0] quotient;
	} div_rsp_t;
endpackage

// File: rtl/alpq_divider.sv
module alpq_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  alpq_pkg::div_req_t  req,
	output alpq_pkg::div_rsp_t  rsp
);
	import alpq_pkg::*;

	logic [12:0] quo_q;
	logic [8:0]  rem_q;
	logic [7:0]  dvs_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [8:0]  trial;
	logic [9:0]  diff;

	assign trial = {rem_q[7:0], quo_q[12]};
	assign diff = {1'b0, trial} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 4'd13;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[9]) begin
				rem_q <= diff[8:0];
				quo_q <= {quo_q[11:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[11:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule

// File: rtl/arc_leak_pulse_qualifier.sv
// Flow: edge, reset and stopped-update transactions go from ST_UPD to ST_OUT; a
// running update goes through ST_FIN to ST_OUT, and through ST_DIV first when the
// one-second rate check runs the 13-step restoring divider that forms the percent.
// Throughput: one transaction at a time; the input stalls while one is in work.
// Reset: arst_n resets the control registers (lockout 3000 us), not the input captures.
module arc_leak_pulse_qualifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] now_us,
	input  logic [31:0] now_ms,
	input  logic        running,
	input  logic        coil_has_fired,
	input  logic [6:0]  base_health,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        leak_detected,
	output logic [31:0] verified_arcs,
	output logic [15:0] arcs_per_second,
	output logic [6:0]  leak_percent,
	output logic [2:0]  severity,
	output logic [6:0]  health,
	output logic        buzzer
);
	import alpq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_UPD, ST_DIV, ST_FIN, ST_OUT
	} state_t;

	state_t state_q;
	logic [7:0] mode_q, cthr_q, cut_q, l25_q, l50_q, l75_q, l100_q;
	logic [15:0] cdeb_q;
	logic [31:0] raw_hits_q, last_edge_us_q, last_edge_ms_q, win_hits_q, win_ms_q;
	logic [31:0] proc_q, total_q, rate_ms_q, snap_q, off_ms_q;
	logic [15:0] lock_q, rate_q;
	logic [6:0] pct_q, hlt_q;
	logic [2:0] sev_q;
	logic det_q, buz_q;
	logic [1:0] op_q;
	logic [31:0] nus_q, nms_q;
	logic run_q, fire_q;
	logic [6:0] bh_q;
	logic [31:0] win_q;
	logic [7:0] base_q;
	logic [2:0] psev_q;
	logic zfix_q;
	div_req_t dreq;
	div_rsp_t drsp;

	logic [7:0] cut, a25, a50, a75, a100, thr;
	logic [15:0] lock;
	always_comb begin
		cut = (cut_q != 8'd0) ? cut_q : 8'd2;
		a25 = (l25_q > cut) ? l25_q : 8'd5;
		a50 = (l50_q > a25) ? l50_q : 8'd10;
		a75 = (l75_q > a50) ? l75_q : 8'd18;
		a100 = (l100_q > a75) ? l100_q : 8'd25;
		unique case (mode_q)
			8'd1: begin lock = 16'd800; thr = 8'd1; end
			8'd2: begin lock = 16'd1500; thr = 8'd2; end
			8'd4: begin lock = 16'd5000; thr = 8'd8; end
			8'd5: begin
				lock = (cdeb_q >= 16'd100) ? cdeb_q : 16'd3000;
				thr = (cthr_q != 8'd0) ? cthr_q : 8'd4;
			end
			default: begin lock = 16'd3000; thr = 8'd4; end
		endcase
	end

	// Update-step combinational values from the registered item.
	logic wnew, leak, rchk;
	logic [31:0] wh, win, tot_n, snapd;
	logic [15:0] rate_n;
	always_comb begin
		wnew = (nms_q - win_ms_q) >= WINDOW_MS;
		wh = wnew ? raw_hits_q : win_hits_q;
		win = raw_hits_q - wh;
		leak = ((nms_q - last_edge_ms_q) < WINDOW_MS) && (win >= {24'd0, thr});
		tot_n = total_q;
		if (raw_hits_q > proc_q && (leak || thr <= 8'd1))
			tot_n = total_q + (raw_hits_q - proc_q);
		rchk = (nms_q - rate_ms_q) >= RATE_MS;
		snapd = tot_n - snap_q;
		rate_n = snapd[15:0];
	end

	logic [15:0] r16;
	logic [12:0] dvd;
	logic [7:0] dvs;
	always_comb begin
		r16 = (state_q == ST_UPD) ? rate_n : rate_q;
		dvd = '0;
		dvs = 8'd1;
		if (r16 <= {8'd0, a25}) begin
			dvd = 13'(r16[8:0] * 9'd25);
			dvs = a25;
		end else if (r16 <= {8'd0, a50}) begin
			dvd = 13'(8'(r16[7:0] - a25) * 9'd25);
			dvs = a50 - a25;
		end else if (r16 <= {8'd0, a75}) begin
			dvd = 13'(8'(r16[7:0] - a75 + a75 - a50) * 9'd25);
			dvs = a75 - a50;
		end else begin
			dvd = (r16 - {8'd0, a75} > 16'd255) ? 13'h1FFF :
				13'(8'(r16 - {8'd0, a75}) * 9'd25);
			dvs = a100 - a75;
		end
	end

	assign dreq.dividend = dvd;
	assign dreq.divisor = dvs;
	assign dreq.start = (state_q == ST_UPD) && (op_q == OP_UPDATE) && run_q && rchk &&
		!(rate_n < {8'd0, cut} && tot_n == 32'd0);

	alpq_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [13:0] psum;
	logic [6:0] pfin;
	assign psum = {6'd0, base_q} + {1'b0, drsp.quotient};
	always_comb begin
		pfin = (psum > 14'd100) ? 7'd100 : psum[6:0];
		if (zfix_q && psum == 14'd0) pfin = 7'd10;
	end

	function automatic logic [6:0] cap(input logic [6:0] p, input logic [6:0] h);
		logic [6:0] r;
		r = h;
		if (p >= 7'd75) begin if (h > 7'd20) r = 7'd20; end
		else if (p >= 7'd50) begin if (h > 7'd50) r = 7'd50; end
		else if (p >= 7'd25) begin if (h > 7'd75) r = 7'd75; end
		return r;
	endfunction

	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign leak_detected = det_q;
	assign verified_arcs = total_q;
	assign arcs_per_second = rate_q;
	assign leak_percent = pct_q;
	assign severity = sev_q;
	assign health = hlt_q;
	assign buzzer = buz_q;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q <= op; nus_q <= now_us; nms_q <= now_ms;
			run_q <= running; fire_q <= coil_has_fired; bh_q <= base_health;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= 8'd3; cdeb_q <= 16'd3000; cthr_q <= 8'd4; cut_q <= 8'd2;
			l25_q <= 8'd5; l50_q <= 8'd10; l75_q <= 8'd18; l100_q <= 8'd25;
			raw_hits_q <= '0; last_edge_us_q <= '0; last_edge_ms_q <= '0;
			lock_q <= 16'd3000; win_hits_q <= '0; win_ms_q <= '0; proc_q <= '0;
			total_q <= '0; rate_ms_q <= '0; snap_q <= '0; rate_q <= '0;
			pct_q <= '0; sev_q <= SEV_INTACT; det_q <= 1'b0; buz_q <= 1'b0;
			off_ms_q <= '0; hlt_q <= '0; win_q <= '0; base_q <= '0;
			psev_q <= SEV_INTACT; zfix_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[7:0];
					CFG_CDEB: cdeb_q <= cfg_data;
					CFG_CTHR: cthr_q <= cfg_data[7:0];
					CFG_CUT: cut_q <= cfg_data[7:0];
					CFG_L25: l25_q <= cfg_data[7:0];
					CFG_L50: l50_q <= cfg_data[7:0];
					CFG_L75: l75_q <= cfg_data[7:0];
					CFG_L100: l100_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_UPD;
				ST_UPD: begin
					hlt_q <= bh_q;
					if (op_q == OP_UPDATE && run_q)
						state_q <= dreq.start ? ST_DIV : ST_FIN;
					else
						state_q <= ST_OUT;
					priority if (op_q == OP_EDGE) begin
						if ((nus_q - last_edge_us_q) >= {16'd0, lock_q}) begin
							last_edge_us_q <= nus_q;
							raw_hits_q <= raw_hits_q + 32'd1;
							last_edge_ms_q <= nms_q;
						end
					end else if (op_q == OP_RESET) begin
						raw_hits_q <= '0; proc_q <= '0; total_q <= '0;
						last_edge_ms_q <= '0; snap_q <= '0; win_hits_q <= '0;
						win_ms_q <= nms_q; rate_q <= '0; det_q <= 1'b0;
						sev_q <= SEV_CLEARED; buz_q <= 1'b0;
					end else if (op_q == OP_UPDATE && !run_q) begin
						det_q <= 1'b0; buz_q <= 1'b0;
					end else if (op_q == OP_UPDATE) begin
						lock_q <= lock;
						if (wnew) begin win_hits_q <= raw_hits_q; win_ms_q <= nms_q; end
						win_q <= win;
						det_q <= leak;
						if (raw_hits_q > proc_q) proc_q <= raw_hits_q;
						total_q <= tot_n;
						if (rchk) begin
							rate_q <= rate_n;
							snap_q <= tot_n;
							rate_ms_q <= nms_q;
						end
						if (!dreq.start && rchk) begin
							pct_q <= '0; sev_q <= SEV_INTACT;
						end
					end
				end
				ST_DIV: begin
					if (r16 <= {8'd0, a25}) begin
						base_q <= 8'd0; psev_q <= SEV_MICRO; zfix_q <= (r16 >= {8'd0, cut});
					end else if (r16 <= {8'd0, a50}) begin
						base_q <= 8'd25; psev_q <= SEV_MODERATE; zfix_q <= 1'b0;
					end else if (r16 <= {8'd0, a75}) begin
						base_q <= 8'd50; psev_q <= SEV_SEVERE; zfix_q <= 1'b0;
					end else begin
						base_q <= 8'd75; psev_q <= SEV_TOTAL; zfix_q <= 1'b0;
					end
					if (drsp.done) begin
						pct_q <= pfin; sev_q <= psev_q; state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					hlt_q <= fire_q ? cap(pct_q, bh_q) : bh_q;
					if (det_q) begin
						if (rate_q > HOLD_RATE || win_q > HOLD_HITS) begin
							buz_q <= 1'b1; off_ms_q <= nms_q + HOLD_MS;
						end else if (nms_q > off_ms_q) begin
							buz_q <= 1'b1; off_ms_q <= nms_q + PULSE_MS;
						end
					end else if (nms_q >= off_ms_q) buz_q <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/alpq_checker.sv
`include "assert_macros.svh"
module alpq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       cfg_ready,
	input logic [6:0] leak_percent,
	input logic [2:0] severity
);
	`CHK_IMPLY(a_busy_no_cfg, clk, arst_n, out_valid, !cfg_ready, "cfg ready during transaction")
	`CHK_IMPLY(a_out_busy, clk, arst_n, out_valid, in_stall, "input open while result pending")
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped")
	`CHK_IMPLY(a_pct_range, clk, arst_n, out_valid, leak_percent <= 7'd100, "percent range")
	`CHK_IMPLY(a_sev_range, clk, arst_n, out_valid, severity <= 3'd5, "severity range")
endmodule

bind arc_leak_pulse_qualifier alpq_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .cfg_ready(cfg_ready),
	.leak_percent(leak_percent), .severity(severity)
);
